// ----- design/countdown_kitchen_timer_assert.svh -----
// Assertion helpers for the countdown timer RTL.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef COUNTDOWN_KITCHEN_TIMER_ASSERT_SVH
`define COUNTDOWN_KITCHEN_TIMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ckt_pkg.sv -----
package ckt_pkg;

    // Depth of the queue between the decoder and the timer core.
    localparam int QUEUE_DEPTH = 2;

    // Input commands.
    localparam logic [1:0] CMD_PRESS  = 2'd0;
    localparam logic [1:0] CMD_REPEAT = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_CLOSE  = 2'd3;

    // Button codes.
    localparam logic [3:0] BTN_START     = 4'd0;
    localparam logic [3:0] BTN_STOP      = 4'd1;
    localparam logic [3:0] BTN_RESET     = 4'd2;
    localparam logic [3:0] BTN_KEY_FIRST = 4'd3;
    localparam logic [3:0] BTN_KEY_LAST  = 4'd10;

    // Decoded operations.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_RESET = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;
    localparam logic [2:0] OP_CLOSE = 3'd5;
    localparam logic [2:0] OP_DIGIT = 3'd6;

    // Digit positions.
    localparam logic [1:0] POS_MIN_TENS = 2'd0;
    localparam logic [1:0] POS_MIN_ONES = 2'd1;
    localparam logic [1:0] POS_SEC_TENS = 2'd2;
    localparam logic [1:0] POS_SEC_ONES = 2'd3;

    // Largest value of a decimal digit and of the seconds tens digit.
    localparam logic [3:0] TOP_NINE = 4'd9;
    localparam logic [3:0] TOP_FIVE = 4'd5;

    // Timer modes.
    localparam logic [2:0] MODE_SETTING  = 3'd0;
    localparam logic [2:0] MODE_RUNNING  = 3'd1;
    localparam logic [2:0] MODE_PAUSED   = 3'd2;
    localparam logic [2:0] MODE_ALARM    = 3'd3;
    localparam logic [2:0] MODE_SILENCED = 3'd4;
    localparam logic [2:0] MODE_CLOSED   = 3'd5;

    // Feedback codes.
    localparam logic [1:0] FB_NONE = 2'd0;
    localparam logic [1:0] FB_OK   = 2'd1;
    localparam logic [1:0] FB_BAD  = 2'd2;

    // One decoded operation as it travels through the queue.
    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] pos;
        logic       up;
    } t_op;

    // One wrapping step of a digit key.
    function automatic logic [3:0] digit_step(input logic [3:0] d, input logic [3:0] top,
                                              input logic up);
        logic [3:0] res;
        if (up) begin
            res = (d >= top) ? 4'd0 : d + 4'd1;
        end else begin
            res = (d == 4'd0 || d > top) ? top : d - 4'd1;
        end
        return res;
    endfunction

endpackage

// ----- design/ckt_front.sv -----
module ckt_front
    import ckt_pkg::*;
(
    input  logic [1:0] i_command,
    input  logic [3:0] i_button,
    output t_op        o_op
);

    logic [3:0] key;
    logic       is_key;

    assign key    = i_button - BTN_KEY_FIRST;
    assign is_key = i_button inside {[BTN_KEY_FIRST:BTN_KEY_LAST]};

    // Key order is minutes tens up, minutes ones up, minutes tens down,
    // minutes ones down, then the same four for seconds.
    always_comb begin
        o_op.kind = OP_NONE;
        o_op.pos  = {key[2], key[0]};
        o_op.up   = ~key[1];
        case (i_command)
            CMD_PRESS: begin
                case (i_button)
                    BTN_START: o_op.kind = OP_START;
                    BTN_STOP:  o_op.kind = OP_STOP;
                    BTN_RESET: o_op.kind = OP_RESET;
                    default:   o_op.kind = is_key ? OP_DIGIT : OP_NONE;
                endcase
            end
            CMD_REPEAT: o_op.kind = is_key ? OP_DIGIT : OP_NONE;
            CMD_TICK:   o_op.kind = OP_TICK;
            CMD_CLOSE:  o_op.kind = OP_CLOSE;
            default:    o_op.kind = OP_NONE;
        endcase
    end

endmodule

// ----- design/ckt_queue.sv -----
module ckt_queue
    import ckt_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_op            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != FullCnt);
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/ckt_core.sv -----
`include "countdown_kitchen_timer_assert.svh"

module ckt_core
    import ckt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_op         i_op,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_data
);

    // Timer state. The digits always hold the remaining time while a count
    // is under way, so a tick is a decimal countdown of mm:ss.
    logic [3:0] r_mt, r_mo, r_so;
    logic [2:0] r_st;
    logic [2:0] r_mode;
    logic       r_counting;
    logic       r_en_start;
    logic       r_en_stop;

    logic [3:0] n_mt, n_mo, n_so;
    logic [2:0] n_st;
    logic [2:0] n_mode;
    logic       n_counting;
    logic       n_en_start;
    logic       n_en_stop;
    logic [1:0] n_fb;

    logic       r_out_valid;
    logic [23:0] r_out_data;

    logic       fire;
    logic       digits_zero;
    logic       last_second;
    logic [3:0] st_step;

    assign o_pop   = i_valid && (!r_out_valid || i_ready);
    assign fire    = o_pop;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    assign digits_zero = (r_mt == 4'd0) && (r_mo == 4'd0) && (r_st == 3'd0) && (r_so == 4'd0);
    assign last_second = (r_mt == 4'd0) && (r_mo == 4'd0) && (r_st == 3'd0) && (r_so <= 4'd1);
    assign st_step     = digit_step({1'b0, r_st}, TOP_FIVE, i_op.up);

    always_comb begin
        n_mt       = r_mt;
        n_mo       = r_mo;
        n_st       = r_st;
        n_so       = r_so;
        n_mode     = r_mode;
        n_counting = r_counting;
        n_en_start = r_en_start;
        n_en_stop  = r_en_stop;
        n_fb       = FB_NONE;
        if (r_mode != MODE_CLOSED) begin
            case (i_op.kind)
                OP_CLOSE: n_mode = MODE_CLOSED;
                OP_TICK: begin
                    if (r_mode == MODE_RUNNING && r_counting) begin
                        if (last_second) begin
                            n_mt       = 4'd0;
                            n_mo       = 4'd0;
                            n_st       = 3'd0;
                            n_so       = 4'd0;
                            n_counting = 1'b0;
                            n_en_start = 1'b0;
                            n_mode     = MODE_ALARM;
                        end else if (r_so != 4'd0) begin
                            n_so = r_so - 4'd1;
                        end else begin
                            n_so = TOP_NINE;
                            if (r_st != 3'd0) begin
                                n_st = r_st - 3'd1;
                            end else begin
                                n_st = TOP_FIVE[2:0];
                                if (r_mo != 4'd0) begin
                                    n_mo = r_mo - 4'd1;
                                end else begin
                                    n_mo = TOP_NINE;
                                    n_mt = r_mt - 4'd1;
                                end
                            end
                        end
                    end
                end
                OP_START: begin
                    case (r_mode)
                        MODE_SETTING: begin
                            // The set digits already read as the total.
                            n_counting = 1'b1;
                            n_fb       = FB_OK;
                            if (!digits_zero) begin
                                n_en_start = 1'b0;
                                n_en_stop  = 1'b1;
                                n_mode     = MODE_RUNNING;
                            end
                        end
                        MODE_PAUSED: begin
                            n_counting = 1'b1;
                            n_en_start = 1'b0;
                            n_en_stop  = 1'b1;
                            n_mode     = MODE_RUNNING;
                            n_fb       = FB_OK;
                        end
                        MODE_SILENCED: begin
                            n_en_start = 1'b0;
                            n_en_stop  = 1'b1;
                            n_mode     = MODE_ALARM;
                            n_fb       = FB_OK;
                        end
                        default: n_fb = FB_BAD;
                    endcase
                end
                OP_STOP: begin
                    case (r_mode)
                        MODE_RUNNING: begin
                            n_counting = 1'b0;
                            n_en_start = 1'b1;
                            n_en_stop  = 1'b0;
                            n_mode     = MODE_PAUSED;
                            n_fb       = FB_OK;
                        end
                        MODE_ALARM: begin
                            n_en_start = 1'b1;
                            n_en_stop  = 1'b0;
                            n_mode     = MODE_SILENCED;
                            n_fb       = FB_OK;
                        end
                        default: n_fb = FB_BAD;
                    endcase
                end
                OP_RESET: begin
                    n_fb = FB_OK;
                    if (r_mode != MODE_ALARM) begin
                        n_mt       = 4'd0;
                        n_mo       = 4'd0;
                        n_st       = 3'd0;
                        n_so       = 4'd0;
                        n_counting = 1'b0;
                    end
                    if (r_mode != MODE_SETTING) begin
                        n_en_start = 1'b1;
                        n_en_stop  = 1'b0;
                        n_mode     = MODE_SETTING;
                    end
                end
                OP_DIGIT: begin
                    if (r_mode == MODE_SETTING) begin
                        case (i_op.pos)
                            POS_MIN_TENS: n_mt = digit_step(r_mt, TOP_NINE, i_op.up);
                            POS_MIN_ONES: n_mo = digit_step(r_mo, TOP_NINE, i_op.up);
                            POS_SEC_TENS: n_st = st_step[2:0];
                            POS_SEC_ONES: n_so = digit_step(r_so, TOP_NINE, i_op.up);
                            default:      n_so = r_so;
                        endcase
                    end
                end
                default: n_fb = FB_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mt        <= 4'd0;
            r_mo        <= 4'd0;
            r_st        <= 3'd0;
            r_so        <= 4'd0;
            r_mode      <= MODE_SETTING;
            r_counting  <= 1'b0;
            r_en_start  <= 1'b1;
            r_en_stop   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_mt       <= n_mt;
                r_mo       <= n_mo;
                r_st       <= n_st;
                r_so       <= n_so;
                r_mode     <= n_mode;
                r_counting <= n_counting;
                r_en_start <= n_en_start;
                r_en_stop  <= n_en_stop;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {1'b0, n_fb, 1'b1, n_en_stop, n_en_start, n_mode,
                           n_so, n_st, n_mo, n_mt};
        end
    end

    `CKT_ASSERT_NEXT(a_closed_holds, r_mode == MODE_CLOSED, r_mode == MODE_CLOSED, "closed left")
    `CKT_ASSERT_NOW(a_running_counts, r_mode == MODE_RUNNING, r_counting, "running without count")
    `CKT_ASSERT_NOW(a_stop_enable, r_mode != MODE_CLOSED, r_en_stop == (r_mode == MODE_RUNNING || r_mode == MODE_ALARM), "stop enable mismatch")
    `CKT_ASSERT_NOW(a_setting_digits, r_mode == MODE_SETTING, r_mt <= TOP_NINE && r_mo <= TOP_NINE && r_st <= TOP_FIVE[2:0] && r_so <= TOP_NINE, "bad digit in setting")

endmodule

// ----- design/countdown_kitchen_timer.sv -----
// Channel   Direction  Contents
// s_axis    in         tuser: command; tdata: button
// m_axis    out        tdata: four digits, mode, button enables, feedback
//
// One transaction is taken per cycle while s_axis_tready is high, and one result
// comes out per cycle while m_axis_tready is high and an operation is queued.
// Each decoded operation is written into the queue; when the core pops it, the
// timer is updated and the output register is loaded.
// Reset is synchronous and active low; it empties the queue and returns the
// timer to setting with a zero time and start and reset enabled.
// When m_axis stalls, the output register holds its result and the queue
// keeps accepting until it is full; s_axis_tready then drops.
module countdown_kitchen_timer
    import ckt_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] button, [7:4] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] minutes_tens, [7:4] minutes_ones, [10:8] seconds_tens,
    // [14:11] seconds_ones, [17:15] mode, [20:18] button_enables,
    // [22:21] feedback, [23] zero
    output logic [23:0] m_axis_tdata
);

    // The decoder turns each command and button into one operation.
    t_op  dec_op;
    // The queue decouples the decoder from the timer core.
    t_op  q_op;
    logic q_valid;
    logic q_pop;

    ckt_front u_front (
        .i_command (s_axis_tuser),
        .i_button  (s_axis_tdata[3:0]),
        .o_op      (dec_op)
    );

    ckt_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_op    (dec_op),
        .o_ready (s_axis_tready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // The core executes one operation per cycle whenever its output
    // register is free or being emptied in the same cycle.
    ckt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_op    (q_op),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// ----- sim/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ckt_pkg::*;

    // Digit keys, as the button field encodes them.
    localparam logic [3:0] KEY_MIN_TENS_UP   = 4'd3;
    localparam logic [3:0] KEY_MIN_ONES_UP   = 4'd4;
    localparam logic [3:0] KEY_MIN_TENS_DOWN = 4'd5;
    localparam logic [3:0] KEY_MIN_ONES_DOWN = 4'd6;
    localparam logic [3:0] KEY_SEC_TENS_UP   = 4'd7;
    localparam logic [3:0] KEY_SEC_ONES_UP   = 4'd8;
    localparam logic [3:0] KEY_SEC_TENS_DOWN = 4'd9;
    localparam logic [3:0] KEY_SEC_ONES_DOWN = 4'd10;
    localparam logic [3:0] BTN_UNUSED_TOP    = 4'd15;

    // Button enable bits of the display.
    localparam logic [2:0] EN_START = 3'b001;
    localparam logic [2:0] EN_STOP  = 3'b010;
    localparam logic [2:0] EN_RESET = 3'b100;

    localparam int unsigned RANDOM_EVENTS = 390;
    localparam int unsigned MAX_LOOP_EVENTS = 40;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned TAIL_CYCLES = 10;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_PRINTED = 100;

    // One display transaction, packed in the order of m_axis_tdata (minutes tens lowest).
    typedef struct packed {
        logic [1:0] feedback;
        logic [2:0] enables;
        logic [2:0] mode;
        logic [3:0] sec_ones;
        logic [2:0] sec_tens;
        logic [3:0] min_ones;
        logic [3:0] min_tens;
    } t_display;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [3:0] button, [7:4] zero
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] minutes_tens, [7:4] minutes_ones, [10:8] seconds_tens,
    // [14:11] seconds_ones, [17:15] mode, [20:18] button_enables,
    // [22:21] feedback, [23] zero
    logic [23:0] m_axis_tdata;

    countdown_kitchen_timer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Behavioral copy of the timer state. It moves only when an input transaction is
    // accepted, so at any moment it reflects every command the block has taken in.
    logic [3:0]  tm_digits [4];
    logic [2:0]  tm_mode;
    logic [12:0] tm_total;
    logic [12:0] tm_elapsed;
    bit          tm_counting;
    logic [2:0]  tm_enables;

    t_display    pending_displays [$];
    int unsigned mismatch_count = 0;
    int unsigned events_sent = 0;

    // Pacing controls set by the tests and read by the sender and receiver; watchdog count.
    bit          tx_gaps_on = 1'b0;
    bit          rx_stalls_on = 1'b0;
    int unsigned rx_hold_request = 0;
    int unsigned rx_stall_left = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Timer prediction
    // ------------------------------------------------------------------------

    // Shows a number of seconds as mm:ss on the four digits.
    function automatic void show_remaining(input logic [12:0] secs);
        int unsigned mins;
        int unsigned rest;
        mins = int'(secs) / 60;
        rest = int'(secs) % 60;
        tm_digits[POS_MIN_TENS] = 4'((mins / 10) & 15);
        tm_digits[POS_MIN_ONES] = 4'(mins % 10);
        tm_digits[POS_SEC_TENS] = 4'((rest / 10) & 7);
        tm_digits[POS_SEC_ONES] = 4'(rest % 10);
    endfunction

    function automatic void clear_time();
        tm_counting = 1'b0;
        foreach (tm_digits[i]) tm_digits[i] = 4'd0;
    endfunction

    // A digit key steps one digit up or down and wraps at the digit's range.
    // Keys are laid out so that bit 0 and bit 2 of the key offset select the digit
    // and bit 1 selects the down direction.
    function automatic void step_digit_key(input logic [3:0] key);
        logic [3:0] offset;
        logic [1:0] pos;
        logic [3:0] top;
        if (key < BTN_KEY_FIRST || key > BTN_KEY_LAST) return;
        offset = key - BTN_KEY_FIRST;
        pos = {offset[2], offset[0]};
        top = (pos == POS_SEC_TENS) ? TOP_FIVE : TOP_NINE;
        if (!offset[1]) begin
            tm_digits[pos] = (tm_digits[pos] >= top) ? 4'd0 : tm_digits[pos] + 4'd1;
        end else begin
            tm_digits[pos] = (tm_digits[pos] == 4'd0 || tm_digits[pos] > top) ?
                             top : tm_digits[pos] - 4'd1;
        end
    endfunction

    // A button press, with the feedback sound it causes.
    function automatic logic [1:0] press_button(input logic [3:0] btn);
        int unsigned secs;
        case (tm_mode)
            MODE_SETTING: begin
                if (btn == BTN_START) begin
                    secs = (int'(tm_digits[POS_MIN_TENS]) * 10 + tm_digits[POS_MIN_ONES]) * 60
                           + int'(tm_digits[POS_SEC_TENS]) * 10 + tm_digits[POS_SEC_ONES];
                    tm_total = 13'(secs);
                    tm_elapsed = '0;
                    tm_counting = 1'b1;
                    show_remaining(tm_total);
                    // A zero time is accepted but the timer stays in setting.
                    if (tm_total != '0) begin
                        tm_enables = EN_RESET | EN_STOP;
                        tm_mode = MODE_RUNNING;
                    end
                    return FB_OK;
                end
                if (btn == BTN_STOP) return FB_BAD;
                if (btn == BTN_RESET) begin
                    clear_time();
                    return FB_OK;
                end
                step_digit_key(btn);
                return FB_NONE;
            end
            MODE_RUNNING, MODE_PAUSED, MODE_SILENCED: begin
                if (btn == BTN_START) begin
                    if (tm_mode == MODE_RUNNING) return FB_BAD;
                    if (tm_mode == MODE_PAUSED) begin
                        tm_counting = 1'b1;
                        tm_mode = MODE_RUNNING;
                    end else begin
                        tm_mode = MODE_ALARM;
                    end
                    tm_enables = EN_RESET | EN_STOP;
                    return FB_OK;
                end
                if (btn == BTN_STOP) begin
                    if (tm_mode != MODE_RUNNING) return FB_BAD;
                    tm_counting = 1'b0;
                    tm_enables = EN_RESET | EN_START;
                    tm_mode = MODE_PAUSED;
                    return FB_OK;
                end
                if (btn == BTN_RESET) begin
                    clear_time();
                    tm_enables = EN_RESET | EN_START;
                    tm_mode = MODE_SETTING;
                    return FB_OK;
                end
                return FB_NONE;
            end
            MODE_ALARM: begin
                if (btn == BTN_START) return FB_BAD;
                if (btn == BTN_STOP || btn == BTN_RESET) begin
                    tm_enables = EN_RESET | EN_START;
                    tm_mode = (btn == BTN_STOP) ? MODE_SILENCED : MODE_SETTING;
                    return FB_OK;
                end
                return FB_NONE;
            end
            default: return FB_NONE;
        endcase
    endfunction

    // A one-second tick counts only while running; reaching the set time clears the
    // digits and raises the alarm with start disabled.
    function automatic void count_second();
        if (tm_mode != MODE_RUNNING || !tm_counting) return;
        tm_elapsed = tm_elapsed + 13'd1;
        if (tm_elapsed >= tm_total) begin
            clear_time();
            tm_enables = EN_RESET | (tm_enables & EN_STOP);
            tm_mode = MODE_ALARM;
        end else begin
            show_remaining(tm_total - tm_elapsed);
        end
    endfunction

    // Advances the timer copy by one command and returns the display it must show.
    function automatic t_display predict_display(input logic [1:0] cmd, input logic [3:0] btn);
        t_display disp;
        logic [1:0] sound;
        sound = FB_NONE;
        if (tm_mode != MODE_CLOSED) begin
            case (cmd)
                CMD_CLOSE:  tm_mode = MODE_CLOSED;
                CMD_TICK:   count_second();
                CMD_PRESS:  sound = press_button(btn);
                CMD_REPEAT: begin
                    // Auto-repeat only moves digits, and only while setting.
                    if (tm_mode == MODE_SETTING) step_digit_key(btn);
                end
                default: ;
            endcase
        end
        disp.min_tens = tm_digits[POS_MIN_TENS];
        disp.min_ones = tm_digits[POS_MIN_ONES];
        disp.sec_tens = tm_digits[POS_SEC_TENS][2:0];
        disp.sec_ones = tm_digits[POS_SEC_ONES];
        disp.mode     = tm_mode;
        disp.enables  = tm_enables;
        disp.feedback = sound;
        return disp;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    // Prints one line per mismatch. After MAX_PRINTED lines further mismatches are
    // still counted but no longer printed, to keep the log readable.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [3:0] got,
                                 input logic [3:0] want);
        if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Every display transaction is matched against the oldest predicted display.
    always @(posedge i_clk) begin : display_check
        t_display got;
        t_display want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[22:0];
            if (pending_displays.size() == 0) begin
                report_mismatch($sformatf("display 0x%06h arrived with none expected",
                                          m_axis_tdata));
            end else begin
                want = pending_displays.pop_front();
                compare_field("minutes tens", got.min_tens, want.min_tens);
                compare_field("minutes ones", got.min_ones, want.min_ones);
                compare_field("seconds tens", {1'b0, got.sec_tens}, {1'b0, want.sec_tens});
                compare_field("seconds ones", got.sec_ones, want.sec_ones);
                compare_field("mode", {1'b0, got.mode}, {1'b0, want.mode});
                compare_field("button enables", {1'b0, got.enables}, {1'b0, want.enables});
                compare_field("feedback", {2'b00, got.feedback}, {2'b00, want.feedback});
            end
        end
    end

    // The watchdog counts cycles in which neither side completes a transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver pacing
    // ------------------------------------------------------------------------

    // The receiver stalls in random bursts while stalls are enabled. A hold request
    // from a test overrides that and keeps tready low for the requested number of
    // cycles, counted down here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_request != 0) begin
            rx_stall_left = rx_hold_request - 1;
            rx_hold_request = 0;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(0, 17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one command transaction and waits until the block takes it. The expected
    // display is predicted at the edge that accepts the transaction. When gaps are
    // enabled, tvalid sometimes drops for a random burst before the offer.
    task automatic send_event(input logic [1:0] cmd, input logic [3:0] btn);
        int unsigned gap;
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'd0, btn};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_displays.push_back(predict_display(cmd, btn));
        events_sent++;
    endtask

    // Drops tvalid and waits until every predicted display has been received. A clock
    // edge passes before the check, so tvalid is never lowered and raised in one step.
    task automatic wait_for_displays();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_displays.size() != 0);
    endtask

    // Random noise: presses, auto-repeats and ticks with any button code, the unused
    // codes included. Close requests are kept out because they end the timer for good.
    task automatic send_noise(input int unsigned count);
        repeat (count) begin
            send_event(2'($urandom_range(CMD_PRESS, CMD_TICK)), 4'($urandom_range(0, 15)));
        end
    endtask

    // One well-formed countdown: reset, enter a short time, start, tick it down with
    // stray commands mixed in, and then play with the alarm.
    task automatic run_countdown();
        int unsigned pick;
        int unsigned loop_events;
        logic [3:0]  key;
        send_event(CMD_PRESS, BTN_RESET);
        repeat ($urandom_range(0, 10)) begin
            pick = $urandom_range(0, 15);
            if (pick < 10)       key = KEY_SEC_ONES_UP;
            else if (pick < 12)  key = KEY_SEC_ONES_DOWN;
            else if (pick == 12) key = KEY_SEC_TENS_UP;
            else if (pick == 13) key = KEY_SEC_TENS_DOWN;
            else if (pick == 14) key = KEY_MIN_ONES_UP;
            else                 key = 4'($urandom_range(BTN_KEY_FIRST, BTN_KEY_LAST));
            send_event($urandom_range(0, 1) ? CMD_REPEAT : CMD_PRESS, key);
        end
        send_event(CMD_PRESS, BTN_START);

        // Long times are cut short by a reset so that one countdown stays brief.
        loop_events = 0;
        while (tm_mode == MODE_RUNNING || tm_mode == MODE_PAUSED) begin
            pick = $urandom_range(0, 39);
            loop_events++;
            if (loop_events > MAX_LOOP_EVENTS) send_event(CMD_PRESS, BTN_RESET);
            else if (pick == 0) send_event(CMD_PRESS, BTN_STOP);
            else if (pick == 1) send_event(CMD_PRESS, BTN_START);
            else if (pick == 2) send_event(CMD_PRESS, 4'($urandom_range(3, 15)));
            else if (pick == 3) send_event(CMD_REPEAT, 4'($urandom_range(0, 15)));
            else if (pick == 4) send_event(CMD_PRESS, BTN_RESET);
            else send_event(CMD_TICK, 4'($urandom_range(0, 15)));
        end

        if (tm_mode == MODE_ALARM) begin
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 4))
                    0: send_event(CMD_PRESS, BTN_START);
                    1: send_event(CMD_PRESS, BTN_STOP);
                    2: send_event(CMD_PRESS, BTN_RESET);
                    3: send_event(CMD_TICK, 4'($urandom_range(0, 15)));
                    default: send_event(CMD_PRESS, 4'($urandom_range(3, 15)));
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Down keys wrap from zero to the top of each digit, which sets the largest time
    // 99:59; that time is started and ticked once. After a reset the up keys, an
    // auto-repeat of a down key, an unused button code and an auto-repeat of a control
    // button are tried, leaving 00:02 on the display.
    task automatic test_digit_keys();
        send_event(CMD_PRESS, KEY_MIN_TENS_DOWN);
        send_event(CMD_PRESS, KEY_MIN_ONES_DOWN);
        send_event(CMD_REPEAT, KEY_SEC_TENS_DOWN);
        send_event(CMD_PRESS, KEY_SEC_ONES_DOWN);
        send_event(CMD_PRESS, BTN_START);
        send_event(CMD_TICK, BTN_START);
        send_event(CMD_PRESS, BTN_RESET);
        send_event(CMD_REPEAT, KEY_MIN_TENS_UP);
        send_event(CMD_PRESS, KEY_SEC_ONES_UP);
        send_event(CMD_PRESS, BTN_UNUSED_TOP);
        send_event(CMD_REPEAT, BTN_START);
        send_event(CMD_REPEAT, KEY_MIN_TENS_DOWN);
        send_event(CMD_PRESS, KEY_SEC_ONES_UP);
    endtask

    // Walks every control button through every mode on a two-second time: rejected
    // stop in setting, start, rejected start while running, pause and resume with a
    // tick that must not count while paused, the alarm, silencing it and sounding it
    // again, reset from the alarm and a start with a zero time.
    task automatic test_control_buttons();
        send_event(CMD_PRESS, BTN_STOP);
        send_event(CMD_PRESS, BTN_START);
        send_event(CMD_REPEAT, BTN_STOP);
        send_event(CMD_PRESS, BTN_START);
        send_event(CMD_TICK, BTN_UNUSED_TOP);
        send_event(CMD_PRESS, BTN_STOP);
        send_event(CMD_TICK, BTN_STOP);
        send_event(CMD_PRESS, BTN_STOP);
        send_event(CMD_PRESS, BTN_START);
        send_event(CMD_PRESS, KEY_SEC_ONES_UP);
        send_event(CMD_TICK, BTN_RESET);
        send_event(CMD_PRESS, BTN_START);
        send_event(CMD_PRESS, BTN_STOP);
        send_event(CMD_PRESS, BTN_START);
        send_event(CMD_PRESS, BTN_RESET);
        send_event(CMD_PRESS, BTN_START);
    endtask

    // Random countdowns with noise in between. Idling on each side is switched on and
    // off per countdown, so some stretches run without gaps.
    task automatic test_random_countdowns(input int unsigned count);
        int unsigned stop_at;
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 6));
            else run_countdown();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // transactions back to back, so the queue fills and the block stalls its input.
    task automatic test_output_backpressure();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        rx_hold_request = HOLD_CYCLES;
        send_event(CMD_PRESS, BTN_RESET);
        repeat (3) send_event(CMD_PRESS, KEY_SEC_ONES_UP);
        send_event(CMD_PRESS, BTN_START);
        repeat (5) send_event(CMD_TICK, 4'($urandom_range(0, 15)));
        send_event(CMD_PRESS, BTN_STOP);
    endtask

    // The sender pauses until every display has arrived, then runs one more countdown.
    task automatic test_drain_pause();
        rx_stalls_on = 1'b1;
        wait_for_displays();
        run_countdown();
    endtask

    // The last part of the run has no idling on either side.
    task automatic test_steady_stream();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (3) run_countdown();
    endtask

    // A close request while running ends the timer; every later command, a second close
    // request included, must leave the display unchanged with no feedback.
    task automatic test_close_request();
        send_event(CMD_PRESS, BTN_RESET);
        repeat (2) send_event(CMD_PRESS, KEY_SEC_ONES_UP);
        send_event(CMD_PRESS, BTN_START);
        send_event(CMD_TICK, BTN_START);
        send_event(CMD_CLOSE, BTN_UNUSED_TOP);
        send_event(CMD_PRESS, BTN_START);
        send_event(CMD_TICK, BTN_START);
        send_event(CMD_PRESS, BTN_STOP);
        send_event(CMD_PRESS, BTN_RESET);
        send_event(CMD_REPEAT, KEY_SEC_ONES_UP);
        send_event(CMD_CLOSE, BTN_START);
        send_event(CMD_PRESS, KEY_MIN_TENS_UP);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= CMD_PRESS;
        s_axis_tdata  <= 8'd0;

        // The timer copy starts from the reset state: setting, 00:00, start and reset on.
        foreach (tm_digits[i]) tm_digits[i] = 4'd0;
        tm_mode     = MODE_SETTING;
        tm_total    = '0;
        tm_elapsed  = '0;
        tm_counting = 1'b0;
        tm_enables  = EN_START | EN_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        test_digit_keys();
        test_control_buttons();
        test_random_countdowns(RANDOM_EVENTS);
        test_output_backpressure();
        test_drain_pause();
        test_steady_stream();
        test_close_request();

        // All stimulus is in; let the last displays drain and watch for strays.
        wait_for_displays();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_displays.size() != 0) begin
            report_mismatch($sformatf("%0d displays never arrived", pending_displays.size()));
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
